### hw/rtl/dbcm_pkg.sv
// Shared types and constants for the divide-by-constant reciprocal generator.
// Used by dbcm_ctrl, dbcm_dp, divide_by_constant_magic and tb; no dependencies.
package dbcm_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int DIVISOR_W     = 32;
  localparam int MAGIC_W       = 32;
  localparam int POST_W        = 6;
  localparam int PRE_W         = 5;

  typedef logic [MAGIC_W-1:0] magic_t;
  typedef logic [POST_W-1:0]  post_t;
  typedef logic [PRE_W-1:0]   pre_t;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_LOG,
    OP_LO_INIT,
    OP_DIV,
    OP_HI_INIT,
    OP_HI_LATCH,
    OP_SHRINK,
    OP_TZ,
    OP_RETRY,
    OP_FINISH
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic bad;
    logic sgn;
    logic retry;
    logic x_zero;
    logic div_done;
    logic shrink_stop;
    logic overflow;
    logic tz_stop;
  } dp_stat_t;

endpackage

### hw/rtl/dbcm_ctrl.sv
// Sequencer for the reciprocal generator: steps the datapath through log,
// divide, shrink and trailing-zero phases. Depends on dbcm_pkg.
module dbcm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dbcm_pkg::dp_stat_t stat,
  output logic              busy,
  output logic              out_valid,
  output dbcm_pkg::dp_op_t  op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG,
    S_LO,
    S_HI,
    S_SHRINK,
    S_TZ,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op        = dbcm_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = dbcm_pkg::OP_LOAD;
          state_nxt = S_LOG;
        end
      end
      S_LOG: begin
        if (stat.bad) begin
          state_nxt = S_FINISH;
        end else if (stat.x_zero) begin
          op        = dbcm_pkg::OP_LO_INIT;
          state_nxt = S_LO;
        end else begin
          op = dbcm_pkg::OP_LOG;
        end
      end
      S_LO: begin
        if (stat.div_done) begin
          op        = dbcm_pkg::OP_HI_INIT;
          state_nxt = S_HI;
        end else begin
          op = dbcm_pkg::OP_DIV;
        end
      end
      S_HI: begin
        if (stat.div_done) begin
          op        = dbcm_pkg::OP_HI_LATCH;
          state_nxt = S_SHRINK;
        end else begin
          op = dbcm_pkg::OP_DIV;
        end
      end
      S_SHRINK: begin
        if (!stat.shrink_stop) begin
          op = dbcm_pkg::OP_SHRINK;
        end else if (!stat.sgn && !stat.retry && stat.overflow) begin
          // multiplier too wide: strip trailing zeros and run again
          state_nxt = S_TZ;
        end else begin
          op        = dbcm_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      S_TZ: begin
        if (stat.tz_stop) begin
          op        = dbcm_pkg::OP_RETRY;
          state_nxt = S_LOG;
        end else begin
          op = dbcm_pkg::OP_TZ;
        end
      end
      S_FINISH: begin
        op        = dbcm_pkg::OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (op == dbcm_pkg::OP_FINISH);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still working");
`endif

endmodule

### hw/rtl/dbcm_dp.sv
// Datapath of the reciprocal generator: bit-serial restoring divider,
// log/shrink/trailing-zero counters and result registers. Depends on dbcm_pkg.
module dbcm_dp #(
  parameter int WORD_BITS = dbcm_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dbcm_pkg::dp_op_t                   op,
  input  logic [dbcm_pkg::DIVISOR_W-1:0]     in_divisor,
  input  logic                               in_mode,
  output dbcm_pkg::dp_stat_t                 stat,
  output dbcm_pkg::magic_t                   out_magic_multiplier,
  output dbcm_pkg::post_t                    out_post_shift,
  output dbcm_pkg::pre_t                     out_pre_shift,
  output logic                               out_needs_fixup,
  output logic                               out_bad_divisor
);

  localparam int W  = WORD_BITS;
  localparam int NW = 2 * W + 1;          // numerator bits
  localparam int QW = W + 2;              // quotient bits kept
  localparam int LW = $clog2(W + 1);      // shift count
  localparam int PW = $clog2(W);          // pre shift count
  localparam int CW = $clog2(NW + 1);     // divide step count
  localparam int SW = $clog2(NW);         // numerator bit index
  localparam logic [W-1:0] HALF_W = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  d_r;
  logic          sgn_r;
  logic          bad_r;
  logic          retry_r;
  logic [W-1:0]  x_r;
  logic [LW-1:0] l_r;
  logic [PW-1:0] pre_r;
  logic [NW-1:0] num_r;
  logic [W-1:0]  rem_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic [QW-1:0] lo_r;
  logic [QW-1:0] hi_r;

  dbcm_pkg::magic_t res_magic_r;
  dbcm_pkg::post_t  res_post_r;
  dbcm_pkg::pre_t   res_pre_r;
  logic             res_fix_r;
  logic             res_bad_r;

  logic [W-1:0]  dw;
  logic          dw_bad;
  logic [SW-1:0] sh_top;
  logic [SW-1:0] sh_low;
  logic [NW-1:0] num_lo;
  logic [NW-1:0] num_hi;
  logic [W:0]    trial;
  logic          ge;
  logic [W:0]    diff;
  logic [W-1:0]  rem_nxt;
  logic          ovf_u;
  logic          ovf_s;

  assign dw     = in_divisor[W-1:0];
  // zero or power of two, or signed magnitude past half range
  assign dw_bad = ((dw & (dw - W'(1))) == '0) || (in_mode && (dw > HALF_W));

  // lo = 2^(W+l) / d, hi = (2^(W+l) + 2^(W+l-prec)) / d
  assign sh_top = SW'(W) + SW'(l_r);
  assign sh_low = sgn_r ? (SW'(l_r) + SW'(1)) : (SW'(l_r) + SW'(pre_r));
  assign num_lo = NW'(1) << sh_top;
  assign num_hi = num_lo | (NW'(1) << sh_low);

  // one restoring divide step
  assign trial   = {rem_r, num_r[NW-1]};
  assign diff    = trial - {1'b0, d_r};
  assign ge      = (trial >= {1'b0, d_r});
  assign rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];

  assign ovf_u = |hi_r[QW-1:W];
  assign ovf_s = |hi_r[QW-1:W-1];

  always_ff @(posedge clk) begin
    case (op)
      dbcm_pkg::OP_LOAD: begin
        d_r     <= dw;
        sgn_r   <= in_mode;
        bad_r   <= dw_bad;
        retry_r <= 1'b0;
        x_r     <= dw - W'(1);
        l_r     <= '0;
        pre_r   <= '0;
      end
      dbcm_pkg::OP_LOG: begin
        x_r <= x_r >> 1;
        l_r <= l_r + LW'(1);
      end
      dbcm_pkg::OP_LO_INIT: begin
        num_r <= num_lo;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CW'(NW);
      end
      dbcm_pkg::OP_DIV: begin
        num_r <= num_r << 1;
        rem_r <= rem_nxt;
        quo_r <= {quo_r[QW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
      end
      dbcm_pkg::OP_HI_INIT: begin
        lo_r  <= quo_r;
        num_r <= num_hi;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CW'(NW);
      end
      dbcm_pkg::OP_HI_LATCH: begin
        hi_r <= quo_r;
      end
      dbcm_pkg::OP_SHRINK: begin
        lo_r <= lo_r >> 1;
        hi_r <= hi_r >> 1;
        l_r  <= l_r - LW'(1);
      end
      dbcm_pkg::OP_TZ: begin
        d_r   <= d_r >> 1;
        pre_r <= pre_r + PW'(1);
      end
      dbcm_pkg::OP_RETRY: begin
        retry_r <= 1'b1;
        x_r     <= d_r - W'(1);
        l_r     <= '0;
      end
      dbcm_pkg::OP_FINISH: begin
        res_bad_r <= bad_r;
        if (bad_r) begin
          res_magic_r <= '0;
          res_post_r  <= '0;
          res_pre_r   <= '0;
          res_fix_r   <= 1'b0;
        end else if (sgn_r) begin
          res_magic_r <= dbcm_pkg::magic_t'(hi_r[W-1:0]);
          res_post_r  <= dbcm_pkg::post_t'(l_r);
          res_pre_r   <= '0;
          res_fix_r   <= ovf_s;
        end else begin
          res_magic_r <= dbcm_pkg::magic_t'(hi_r[W-1:0]);
          res_pre_r   <= dbcm_pkg::pre_t'(pre_r);
          res_fix_r   <= ovf_u;
          // fixup lowers the shift, but never below zero
          if (ovf_u && (l_r != '0)) begin
            res_post_r <= dbcm_pkg::post_t'(l_r - LW'(1));
          end else begin
            res_post_r <= dbcm_pkg::post_t'(l_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.bad         = bad_r;
  assign stat.sgn         = sgn_r;
  assign stat.retry       = retry_r;
  assign stat.x_zero      = (x_r == '0);
  assign stat.div_done    = (cnt_r == '0);
  assign stat.shrink_stop = (l_r == '0) || (lo_r[QW-1:1] == hi_r[QW-1:1]);
  assign stat.overflow    = ovf_u;
  assign stat.tz_stop     = d_r[0] || (pre_r == PW'(W - 1));

  assign out_magic_multiplier = res_magic_r;
  assign out_post_shift       = res_post_r;
  assign out_pre_shift        = res_pre_r;
  assign out_needs_fixup      = res_fix_r;
  assign out_bad_divisor      = res_bad_r;

`ifndef SYNTHESIS
  a_rem_below_d: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dbcm_pkg::OP_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below divisor");

  a_shrink_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dbcm_pkg::OP_SHRINK) |-> (l_r != '0))
    else $error("shrink step with zero shift");
`endif

endmodule

### hw/rtl/divide_by_constant_magic.sv
// Sequence: for a bad divisor the sequencer passes from S_LOG to S_FINISH;
// otherwise each pass runs the log scan, the lo and hi divides and the shrink
// steps, using the one-bit-per-cycle restoring divider (the unsigned retry
// adds a trailing-zero scan and a second pass).
// Throughput: one word at a time; start is taken again in the out_valid cycle.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
module divide_by_constant_magic #(
  parameter int WORD_BITS = dbcm_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dbcm_pkg::DIVISOR_W-1:0] in_divisor,
  input  logic                           in_mode,
  output logic                           out_valid,
  output dbcm_pkg::magic_t               out_magic_multiplier,
  output dbcm_pkg::post_t                out_post_shift,
  output dbcm_pkg::pre_t                 out_pre_shift,
  output logic                           out_needs_fixup,
  output logic                           out_bad_divisor
);

  dbcm_pkg::dp_op_t   op;
  dbcm_pkg::dp_stat_t stat;

  dbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .op        (op)
  );

  dbcm_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .op                   (op),
    .in_divisor           (in_divisor),
    .in_mode              (in_mode),
    .stat                 (stat),
    .out_magic_multiplier (out_magic_multiplier),
    .out_post_shift       (out_post_shift),
    .out_pre_shift        (out_pre_shift),
    .out_needs_fixup      (out_needs_fixup),
    .out_bad_divisor      (out_bad_divisor)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for divide_by_constant_magic: predicts each reciprocal
// word in SystemVerilog and compares it field by field. Depends on dbcm_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS    = dbcm_pkg::WORD_BITS_DEF;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 1000;

  typedef bit [63:0] u64_t;

  typedef struct packed {
    dbcm_pkg::magic_t magic_multiplier;
    dbcm_pkg::post_t  post_shift;
    dbcm_pkg::pre_t   pre_shift;
    logic             needs_fixup;
    logic             bad_divisor;
  } magic_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic [dbcm_pkg::DIVISOR_W-1:0] in_divisor = '0;
  logic                           in_mode = 1'b0;
  logic                           busy;
  logic                           out_valid;
  dbcm_pkg::magic_t               out_magic_multiplier;
  dbcm_pkg::post_t                out_post_shift;
  dbcm_pkg::pre_t                 out_pre_shift;
  logic                           out_needs_fixup;
  logic                           out_bad_divisor;

  magic_result_t pending_magic[$];
  int            mismatch_count = 0;
  int            burst_left = 0;

  divide_by_constant_magic #(.WORD_BITS(WORD_BITS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_divisor          (in_divisor),
    .in_mode             (in_mode),
    .out_valid           (out_valid),
    .out_magic_multiplier(out_magic_multiplier),
    .out_post_shift      (out_post_shift),
    .out_pre_shift       (out_pre_shift),
    .out_needs_fixup     (out_needs_fixup),
    .out_bad_divisor     (out_bad_divisor)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic u64_t pow2_64(int e);
    if (e < 0 || e > 63) return 64'd0;
    return 64'd1 << e;
  endfunction

  function automatic int msb_index(u64_t x);
    int b;
    b = -1;
    while (x != 0) begin
      b++;
      x = x >> 1;
    end
    return b;
  endfunction

  // Return the shift; mult gets the full-width multiplier (may overflow a word).
  function automatic int reciprocal_shift(u64_t d, int prec, output u64_t mult);
    int   l;
    u64_t lo, hi;
    l  = msb_index(d - 64'd1) + 1;
    lo = ((pow2_64(l) - d) << WORD_BITS) / d + pow2_64(WORD_BITS);
    if (l + prec == 2 * WORD_BITS)
      hi = ((pow2_64(l) + 64'd1 - d) << WORD_BITS) / d + pow2_64(WORD_BITS);
    else
      hi = (pow2_64(WORD_BITS + l) + pow2_64(WORD_BITS + l - prec)) / d;
    // halve both bounds while they stay distinct
    while (l > 0 && (lo >> 1) != (hi >> 1)) begin
      lo = lo >> 1;
      hi = hi >> 1;
      l--;
    end
    mult = hi;
    return l;
  endfunction

  function automatic magic_result_t predict_magic(logic [dbcm_pkg::DIVISOR_W-1:0] divisor,
                                                  logic mode);
    magic_result_t r;
    u64_t          wmask, d, dd, m;
    int            s, pre;
    logic          fix, bad;
    wmask = pow2_64(WORD_BITS) - 64'd1;
    d     = u64_t'(divisor) & wmask;
    m     = 64'd0;
    s     = 0;
    pre   = 0;
    fix   = 1'b0;
    bad   = (d == 0) || ((d & (d - 64'd1)) == 0);
    if (!bad && mode && d > pow2_64(WORD_BITS - 1)) bad = 1'b1;
    if (!bad) begin
      if (mode) begin
        s   = reciprocal_shift(d, WORD_BITS - 1, m);
        fix = (m >= pow2_64(WORD_BITS - 1));
      end else begin
        s = reciprocal_shift(d, WORD_BITS, m);
        if (m >= pow2_64(WORD_BITS)) begin
          // strip trailing zeros into the pre shift and retry
          dd = d;
          while (dd[0] == 1'b0 && pre < WORD_BITS - 1) begin
            dd = dd >> 1;
            pre++;
          end
          s = reciprocal_shift(dd, WORD_BITS - pre, m);
        end
        if (m >= pow2_64(WORD_BITS)) begin
          fix = 1'b1;
          if (s > 0) s--;
        end
      end
    end
    r.magic_multiplier = dbcm_pkg::magic_t'(m & wmask);
    r.post_shift       = dbcm_pkg::post_t'(s);
    r.pre_shift        = dbcm_pkg::pre_t'(pre);
    r.needs_fixup      = fix;
    r.bad_divisor      = bad;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    magic_result_t want;
    if (rst_n && out_valid) begin
      if (pending_magic.size() == 0) begin
        $error("result word with no divisor pending");
        mismatch_count++;
      end else begin
        want = pending_magic.pop_front();
        compare_field("magic_multiplier", want.magic_multiplier, out_magic_multiplier);
        compare_field("post_shift", want.post_shift, out_post_shift);
        compare_field("pre_shift", want.pre_shift, out_pre_shift);
        compare_field("needs_fixup", want.needs_fixup, out_needs_fixup);
        compare_field("bad_divisor", want.bad_divisor, out_bad_divisor);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Hold start high until the word is taken; start stays high for the caller.
  task automatic issue_divisor(input logic [dbcm_pkg::DIVISOR_W-1:0] d, input logic m);
    start      <= 1'b1;
    in_divisor <= d;
    in_mode    <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_magic.push_back(predict_magic(d, m));
  endtask

  task automatic paced_issue(input logic [dbcm_pkg::DIVISOR_W-1:0] d, input logic m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 600) : $urandom_range(0, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    issue_divisor(d, m);
  endtask

  function automatic logic [dbcm_pkg::DIVISOR_W-1:0] rand_divisor();
    logic [dbcm_pkg::DIVISOR_W-1:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2: d = $urandom;
      3:       d = $urandom_range(0, 64);
      4:       d = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
      5:       d = (($urandom >> $urandom_range(0, 31)) | 32'd1) << $urandom_range(0, 16);
      6:       d = 32'h8000_0000 + $urandom_range(0, 4) - 2;
      7:       d = {1'b1, 31'($urandom)};
      default: d = $urandom >> $urandom_range(0, 31);
    endcase
    return d;
  endfunction

  task automatic test_directed();
    issue_divisor(32'd0, 1'b0);
    issue_divisor(32'd0, 1'b1);
    issue_divisor(32'd1, 1'b0);
    issue_divisor(32'd2, 1'b1);
    issue_divisor(32'h8000_0000, 1'b0);
    issue_divisor(32'h8000_0000, 1'b1);
    issue_divisor(32'd3, 1'b0);
    issue_divisor(32'd3, 1'b1);
    issue_divisor(32'd5, 1'b0);
    issue_divisor(32'd6, 1'b0);
    issue_divisor(32'd7, 1'b0);
    issue_divisor(32'd7, 1'b1);
    issue_divisor(32'd14, 1'b0);
    issue_divisor(32'd28, 1'b0);
    issue_divisor(32'd641, 1'b0);
    issue_divisor(32'd10, 1'b1);
    issue_divisor(32'h7FFF_FFFF, 1'b0);
    issue_divisor(32'h7FFF_FFFF, 1'b1);
    issue_divisor(32'h8000_0001, 1'b0);
    issue_divisor(32'h8000_0001, 1'b1);
    issue_divisor(32'hFFFF_FFFF, 1'b0);
    issue_divisor(32'hFFFF_FFFF, 1'b1);
    issue_divisor(32'hFFFF_FFFE, 1'b0);
    issue_divisor(32'hC000_0000, 1'b0);
    issue_divisor(32'h5555_5555, 1'b1);
  endtask

  task automatic test_random_unsigned(input int count);
    repeat (count) paced_issue(rand_divisor(), 1'b0);
  endtask

  task automatic test_random_signed(input int count);
    logic [dbcm_pkg::DIVISOR_W-1:0] d;
    repeat (count) begin
      d = rand_divisor();
      // keep most magnitudes in range; the rest exercise the too-large case
      if (d > 32'h8000_0000 && $urandom_range(0, 7) != 0) d = {1'b0, d[30:0]};
      paced_issue(d, 1'b1);
    end
  endtask

  // Even unsigned divisors drive the trailing-zero retry path
  task automatic test_even_divisors(input int count);
    logic [dbcm_pkg::DIVISOR_W-1:0] odd_part;
    repeat (count) begin
      odd_part = ($urandom >> $urandom_range(0, 31)) | 32'd1;
      paced_issue(odd_part << $urandom_range(1, 31), 1'b0);
    end
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) issue_divisor(rand_divisor(), 1'(($urandom_range(0, 1))));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_unsigned(250);
    test_random_signed(250);
    test_even_divisors(150);
    test_back_to_back(100);
    start <= 1'b0;
    while (pending_magic.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### divide_by_constant_magic.f
hw/rtl/dbcm_pkg.sv
hw/rtl/dbcm_ctrl.sv
hw/rtl/dbcm_dp.sv
hw/rtl/divide_by_constant_magic.sv
tb/tb.sv
